@@ hw/rtl/hpss_pkg.sv @@
// Shared types and fixed field widths of the median guide block.
// Used by the sorting cells, the sorting row and the top level; no dependencies.
package hpss_pkg;

   localparam int MAG_W   = 16;
   localparam int GUIDE_W = 17;
   localparam int IDX_W   = 11;
   localparam int CFG_W   = 12;
   localparam logic [CFG_W-1:0] BINS_RESET = 12'd1025;

   // One slot of the sorting row; an empty slot ranks above every value.
   typedef struct packed {
      logic             valid;
      logic [MAG_W-1:0] val;
   } slot_type;

   // Control shared by every cell of the sorting row.
   typedef struct packed {
      logic clear;
      logic push;
   } sort_ctl_type;

endpackage

@@ hw/rtl/hpss_hist_mem.sv @@
// Single-port-write, single-port-read history memory with registered read data.
// Stand-alone; no package dependency.
module hpss_hist_mem #(
   parameter int DEPTH  = 34816,
   parameter int ADDR_W = 16,
   parameter int WIDTH  = 16
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/hpss_sort_cell.sv @@
// One cell of the insertion-sorting row: holds one value, takes its left
// neighbor's value when the new key is smaller. Depends on hpss_pkg.
module hpss_sort_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  hpss_pkg::sort_ctl_type        ctl,
   input  logic [hpss_pkg::MAG_W-1:0]    din,
   input  hpss_pkg::slot_type            left,
   output hpss_pkg::slot_type            slot_q
);

   hpss_pkg::slot_type slot_ff, slot_in;
   logic shift_w, take_w;

   always_comb begin
      shift_w = left.valid ? (din < left.val) : 1'b1;
      take_w  = !slot_ff.valid || (din < slot_ff.val);
      slot_in = slot_ff;
      if (ctl.clear) begin
         slot_in.valid = 1'b0;
      end else if (ctl.push) begin
         if (shift_w) begin
            slot_in = left;
         end else if (take_w) begin
            slot_in.valid = 1'b1;
            slot_in.val   = din;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
         slot_ff.val   <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot_q = slot_ff;

endmodule

@@ hw/rtl/hpss_sort_row.sv @@
// Row of sorting cells kept in ascending order, one insertion per cycle,
// plus the fill count. Depends on hpss_pkg and hpss_sort_cell.
module hpss_sort_row #(
   parameter int NCELL = 17,
   parameter int CNT_W = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hpss_pkg::sort_ctl_type     ctl,
   input  logic [hpss_pkg::MAG_W-1:0] din,
   output logic [hpss_pkg::MAG_W-1:0] vals [NCELL],
   output logic [CNT_W-1:0]           count
);

   hpss_pkg::slot_type chain [NCELL+1];
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // The head of the chain acts as a value below every key.
   assign chain[0] = '{valid: 1'b1, val: '0};

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      hpss_sort_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .din    (din),
         .left   (chain[i]),
         .slot_q (chain[i+1])
      );
      assign vals[i] = chain[i+1].val;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.clear) begin
         cnt_in = '0;
      end else if (ctl.push && (cnt_ff != CNT_W'(NCELL))) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign count = cnt_ff;

endmodule

@@ hw/rtl/hpss_median_guides_top.sv @@
// Each item is written to the history memory, the held frames (up to HISTORY_FRAMES) are read back
// through the sorting row for the time median, and the frequency window is then loaded into the row
// once per result bin. Only one item is in flight at a time; the frame's last bin also flushes the
// remaining bins of the window.
// Reset clears the control state and sets the bin count register cfg_ff to 1025; the memories are not cleared.
// Depends on hpss_pkg, hpss_sort_row and hpss_hist_mem.
module hpss_median_guides_top #(
   parameter int MAX_BINS       = 2048,
   parameter int HISTORY_FRAMES = 17,
   parameter int FREQ_WINDOW    = 17
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [hpss_pkg::MAG_W-1:0]   req_magnitude,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hpss_pkg::IDX_W-1:0]   rsp_bin_index,
   output logic [hpss_pkg::GUIDE_W-1:0] rsp_horizontal_guide_x2,
   output logic [hpss_pkg::GUIDE_W-1:0] rsp_vertical_guide_x2,
   output logic                         rsp_frame_last,
   input  logic                         csr_we,
   input  logic [hpss_pkg::CFG_W-1:0]   csr_wdata
);

   localparam int HALF     = FREQ_WINDOW / 2;
   localparam int WIN_SPAN = 2 * HALF + 1;
   localparam int DD       = HALF + 1;
   localparam int NCELL    = (HISTORY_FRAMES > WIN_SPAN) ? HISTORY_FRAMES : WIN_SPAN;
   localparam int CNT_W    = $clog2(NCELL + 1);
   localparam int IX_W     = (NCELL > 1) ? $clog2(NCELL) : 1;
   localparam int BIN_W    = $clog2(MAX_BINS);
   localparam int SLOT_W   = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
   localparam int FS_W     = $clog2(HISTORY_FRAMES + 1);
   localparam int ADDR_W   = $clog2(HISTORY_FRAMES * MAX_BINS);
   localparam int WP_W     = (WIN_SPAN > 1) ? $clog2(WIN_SPAN) : 1;
   localparam int HP_W     = (DD > 1) ? $clog2(DD) : 1;
   localparam int EW       = (BIN_W + 1 > hpss_pkg::CFG_W) ? BIN_W + 1 : hpss_pkg::CFG_W;
   localparam int XW       = (BIN_W > hpss_pkg::IDX_W) ? BIN_W : hpss_pkg::IDX_W;
   localparam int MW       = hpss_pkg::MAG_W;
   localparam int GW       = hpss_pkg::GUIDE_W;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_HWR   = 8'b0000_0010,
      S_HRD   = 8'b0000_0100,
      S_HMED  = 8'b0000_1000,
      S_VSET  = 8'b0001_0000,
      S_VFILL = 8'b0010_0000,
      S_VMED  = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   // Control state.
   state_type             state_ff, state_in;
   logic [hpss_pkg::CFG_W-1:0] cfg_ff, cfg_in;
   logic [BIN_W-1:0]      bin_ff, bin_in;
   logic [WP_W-1:0]       wpos_ff, wpos_in;
   logic [HP_W-1:0]       hpos_ff, hpos_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [FS_W-1:0]       frames_ff, frames_in;
   logic                  pend_ff, pend_in;

   // Per-transaction working registers.
   logic [MW-1:0]         mag_ff, mag_in;
   logic [BIN_W-1:0]      c_ff, c_in;
   logic                  last_ff, last_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SLOT_W-1:0]     cur_slot_ff, cur_slot_in;
   logic [SLOT_W-1:0]     rd_slot_ff, rd_slot_in;
   logic [CNT_W-1:0]      iss_ff, iss_in;
   logic [WP_W-1:0]       ipw_ff, ipw_in;
   logic [HP_W-1:0]       iph_ff, iph_in;
   logic [BIN_W-1:0]      b_ff, b_in;
   logic [BIN_W-1:0]      bend_ff, bend_in;
   logic [WP_W-1:0]       gp_ff, gp_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic [XW-1:0]         obin_ff, obin_in;
   logic [GW-1:0]         oh_ff, oh_in;
   logic [GW-1:0]         ov_ff, ov_in;
   logic                  olast_ff, olast_in;

   logic [MW-1:0]         window_mem [WIN_SPAN];
   logic [GW-1:0]         hdelay_mem [DD];

   // Combinational helpers.
   logic                  accept_w;
   logic [EW-1:0]         eff_w;
   logic                  last_w;
   logic [CNT_W-1:0]      cnt_w;
   logic                  win_we_w;
   logic                  hd_we_w;
   logic [HP_W:0]         hd_d_w;
   logic [HP_W:0]         hd_pos_w;
   logic [BIN_W-1:0]      lo_w;
   logic [CNT_W-1:0]      n_w;
   logic                  c_ge_half_w;
   logic [BIN_W-1:0]      b0_w;

   hpss_pkg::sort_ctl_type srt_ctl;
   logic [MW-1:0]         srt_din;
   logic [MW-1:0]         srt_vals [NCELL];
   logic [CNT_W-1:0]      srt_cnt;
   logic [IX_W-1:0]       mid_w;
   logic [GW-1:0]         med_w;

   logic                  mem_we, mem_re;
   logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
   logic [MW-1:0]         mem_rdata;

   hpss_sort_row #(
      .NCELL (NCELL),
      .CNT_W (CNT_W)
   ) u_row (
      .clock (clock),
      .reset (reset),
      .ctl   (srt_ctl),
      .din   (srt_din),
      .vals  (srt_vals),
      .count (srt_cnt)
   );

   hpss_hist_mem #(
      .DEPTH  (HISTORY_FRAMES * MAX_BINS),
      .ADDR_W (ADDR_W),
      .WIDTH  (MW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mag_ff),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Exact median at twice its value from the sorted row.
   always_comb begin
      mid_w = IX_W'(srt_cnt >> 1);
      if (srt_cnt[0]) begin
         med_w = {srt_vals[mid_w], 1'b0};
      end else begin
         med_w = GW'(srt_vals[mid_w - 1'b1]) + GW'(srt_vals[mid_w]);
      end
   end

   always_comb begin
      accept_w = req_valid && req_ready;
      if (cfg_ff == '0) begin
         eff_w = EW'(1);
      end else if (EW'(cfg_ff) > EW'(MAX_BINS)) begin
         eff_w = EW'(MAX_BINS);
      end else begin
         eff_w = EW'(cfg_ff);
      end
      last_w = (EW'(bin_ff) + 1'b1) >= eff_w;
      if (frames_ff == FS_W'(HISTORY_FRAMES)) begin
         cnt_w = CNT_W'(HISTORY_FRAMES);
      end else begin
         cnt_w = CNT_W'(frames_ff) + 1'b1;
      end

      c_ge_half_w = c_ff >= BIN_W'(HALF);
      b0_w = c_ge_half_w ? (c_ff - BIN_W'(HALF)) : '0;
      lo_w = (b_ff >= BIN_W'(HALF)) ? (b_ff - BIN_W'(HALF)) : '0;
      n_w  = CNT_W'(c_ff - lo_w) + 1'b1;

      // Delay-line slot of bin b, counted back from the current bin's slot.
      hd_d_w = (HP_W+1)'(c_ff - b_ff);
      if ({1'b0, iph_ff} >= hd_d_w) begin
         hd_pos_w = {1'b0, iph_ff} - hd_d_w;
      end else begin
         hd_pos_w = {1'b0, iph_ff} + (HP_W+1)'(DD) - hd_d_w;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cfg_in      = csr_we ? csr_wdata : cfg_ff;
      bin_in      = bin_ff;
      wpos_in     = wpos_ff;
      hpos_in     = hpos_ff;
      slot_in     = slot_ff;
      frames_in   = frames_ff;
      pend_in     = 1'b0;
      mag_in      = mag_ff;
      c_in        = c_ff;
      last_in     = last_ff;
      cnt_in      = cnt_ff;
      cur_slot_in = cur_slot_ff;
      rd_slot_in  = rd_slot_ff;
      iss_in      = iss_ff;
      ipw_in      = ipw_ff;
      iph_in      = iph_ff;
      b_in        = b_ff;
      bend_in     = bend_ff;
      gp_in       = gp_ff;
      left_in     = left_ff;
      obin_in     = obin_ff;
      oh_in       = oh_ff;
      ov_in       = ov_ff;
      olast_in    = olast_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      srt_ctl     = '0;
      srt_din     = mag_ff;
      win_we_w    = 1'b0;
      hd_we_w     = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_waddr   = ADDR_W'(ADDR_W'(cur_slot_ff) * ADDR_W'(MAX_BINS) + ADDR_W'(c_ff));
      mem_raddr   = ADDR_W'(ADDR_W'(rd_slot_ff) * ADDR_W'(MAX_BINS) + ADDR_W'(c_ff));

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (accept_w) begin
               mag_in      = req_magnitude;
               c_in        = bin_ff;
               last_in     = last_w;
               cnt_in      = cnt_w;
               cur_slot_in = slot_ff;
               ipw_in      = wpos_ff;
               iph_in      = hpos_ff;
               win_we_w    = 1'b1;
               srt_ctl.clear = 1'b1;
               if (last_w) begin
                  bin_in  = '0;
                  wpos_in = '0;
                  hpos_in = '0;
                  slot_in = (slot_ff == SLOT_W'(HISTORY_FRAMES - 1)) ? '0 : slot_ff + 1'b1;
                  if (frames_ff != FS_W'(HISTORY_FRAMES)) begin
                     frames_in = frames_ff + 1'b1;
                  end
               end else begin
                  bin_in  = bin_ff + 1'b1;
                  wpos_in = (wpos_ff == WP_W'(WIN_SPAN - 1)) ? '0 : wpos_ff + 1'b1;
                  hpos_in = (hpos_ff == HP_W'(DD - 1)) ? '0 : hpos_ff + 1'b1;
               end
               state_in = S_HWR;
            end
         end
         S_HWR: begin
            mem_we       = 1'b1;
            srt_ctl.push = 1'b1;
            rd_slot_in   = (cur_slot_ff == '0) ? SLOT_W'(HISTORY_FRAMES - 1)
                                               : cur_slot_ff - 1'b1;
            iss_in       = CNT_W'(1);
            state_in     = S_HRD;
         end
         S_HRD: begin
            // Reads stream out of the memory; each word joins the row in the cycle after its read.
            if (iss_ff != cnt_ff) begin
               mem_re     = 1'b1;
               pend_in    = 1'b1;
               iss_in     = iss_ff + 1'b1;
               rd_slot_in = (rd_slot_ff == '0) ? SLOT_W'(HISTORY_FRAMES - 1)
                                              : rd_slot_ff - 1'b1;
            end
            if (pend_ff) begin
               srt_ctl.push = 1'b1;
               srt_din      = mem_rdata;
            end
            if ((iss_ff == cnt_ff) && !pend_ff) begin
               state_in = S_HMED;
            end
         end
         S_HMED: begin
            hd_we_w = 1'b1;
            b_in    = b0_w;
            bend_in = last_ff ? c_ff : b0_w;
            if (c_ge_half_w || last_ff) begin
               state_in = S_VSET;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_VSET: begin
            srt_ctl.clear = 1'b1;
            gp_in    = ipw_ff;
            left_in  = n_w;
            state_in = S_VFILL;
         end
         S_VFILL: begin
            srt_ctl.push = 1'b1;
            srt_din      = window_mem[gp_ff];
            gp_in        = (gp_ff == '0) ? WP_W'(WIN_SPAN - 1) : gp_ff - 1'b1;
            left_in      = left_ff - 1'b1;
            if (left_ff == CNT_W'(1)) begin
               state_in = S_VMED;
            end
         end
         S_VMED: begin
            obin_in  = XW'(b_ff);
            oh_in    = hdelay_mem[HP_W'(hd_pos_w)];
            ov_in    = med_w;
            olast_in = last_ff && (b_ff == c_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (b_ff == bend_ff) begin
                  state_in = S_IDLE;
               end else begin
                  b_in     = b_ff + 1'b1;
                  state_in = S_VSET;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cfg_ff    <= hpss_pkg::BINS_RESET;
         bin_ff    <= '0;
         wpos_ff   <= '0;
         hpos_ff   <= '0;
         slot_ff   <= '0;
         frames_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cfg_ff    <= cfg_in;
         bin_ff    <= bin_in;
         wpos_ff   <= wpos_in;
         hpos_ff   <= hpos_in;
         slot_ff   <= slot_in;
         frames_ff <= frames_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      c_ff        <= c_in;
      last_ff     <= last_in;
      cnt_ff      <= cnt_in;
      cur_slot_ff <= cur_slot_in;
      rd_slot_ff  <= rd_slot_in;
      iss_ff      <= iss_in;
      ipw_ff      <= ipw_in;
      iph_ff      <= iph_in;
      b_ff        <= b_in;
      bend_ff     <= bend_in;
      gp_ff       <= gp_in;
      left_ff     <= left_in;
      obin_ff     <= obin_in;
      oh_ff       <= oh_in;
      ov_ff       <= ov_in;
      olast_ff    <= olast_in;
      if (win_we_w) begin
         window_mem[wpos_ff] <= req_magnitude;
      end
      if (hd_we_w) begin
         hdelay_mem[iph_ff] <= med_w;
      end
   end

   assign rsp_bin_index           = obin_ff[hpss_pkg::IDX_W-1:0];
   assign rsp_horizontal_guide_x2 = oh_ff;
   assign rsp_vertical_guide_x2   = ov_ff;
   assign rsp_frame_last          = olast_ff;

`ifndef SYNTHESIS
   // Only one transaction is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while a transaction is in flight");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      srt_cnt <= CNT_W'(NCELL))
      else $error("sorting row count above its cell count");

   // The frame's last result leaves only after the bin counter has wrapped.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_frame_last) |=> (bin_ff == '0))
      else $error("frame end result while bin counter not wrapped");

   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VFILL) |-> (left_ff != '0))
      else $error("window fill with nothing left to load");
`endif

endmodule

@@ test/hpss_median_guides_top_tb.sv @@
// Self-checking testbench for hpss_median_guides_top: random magnitude frames with
// bursty input, a stalling result side and a scoreboard that predicts both guides.
// Depends on hpss_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module hpss_median_guides_top_tb;

   localparam int MAX_BINS  = 2048;
   localparam int HIST      = 17;
   localparam int WIN       = 17;
   localparam int HALF      = WIN / 2;
   localparam int DELAY     = HALF + 1;
   localparam int SETTLE    = 400;
   localparam int LIMIT     = 1_500_000;

   typedef struct packed {
      logic [hpss_pkg::IDX_W-1:0]   bin;
      logic [hpss_pkg::GUIDE_W-1:0] horiz;
      logic [hpss_pkg::GUIDE_W-1:0] vert;
      logic                         last;
   } guide_type;

   // Predicts the guides of every accepted magnitude and checks the results in order.
   class guide_scoreboard_type;
      logic [hpss_pkg::MAG_W-1:0]   history [HIST][MAX_BINS];
      logic [hpss_pkg::MAG_W-1:0]   window_mag [WIN];
      logic [hpss_pkg::GUIDE_W-1:0] horiz_delay [DELAY];
      int unsigned                  slot, frames, next_bin, bins_used;
      guide_type                    expected_q [$];
      int                           mismatches;

      function new();
         slot = 0;
         frames = 0;
         next_bin = 0;
         bins_used = int'(hpss_pkg::BINS_RESET);
         mismatches = 0;
      endfunction

      function int unsigned median_x2(int unsigned vals [$]);
         int unsigned n;
         vals.sort();
         n = vals.size();
         if (n % 2 == 1) return 2 * vals[n/2];
         return vals[n/2 - 1] + vals[n/2];
      endfunction

      function void push_result(int unsigned b, int unsigned top, bit is_last);
         int unsigned vals [$];
         int unsigned lo, hi;
         guide_type g;
         lo = (b >= HALF) ? b - HALF : 0;
         hi = (b + HALF > top) ? top : b + HALF;
         for (int unsigned i = lo; i <= hi; i++) vals.push_back(window_mag[i % WIN]);
         g.bin   = b[hpss_pkg::IDX_W-1:0];
         g.horiz = horiz_delay[b % DELAY];
         g.vert  = hpss_pkg::GUIDE_W'(median_x2(vals));
         g.last  = (b == top) && is_last;
         expected_q.push_back(g);
      endfunction

      function void set_bins(int unsigned v);
         bins_used = v;
      endfunction

      function void note_input(logic [hpss_pkg::MAG_W-1:0] mag);
         int unsigned used, c, depth, s;
         int unsigned vals [$];
         bit last;
         used = (bins_used == 0) ? 1 : (bins_used > MAX_BINS) ? MAX_BINS : bins_used;
         c = next_bin;
         last = (c + 1 >= used);
         history[slot][c] = mag;
         depth = (frames + 1 > HIST) ? HIST : frames + 1;
         s = slot;
         for (int k = 0; k < depth; k++) begin
            vals.push_back(history[s][c]);
            s = (s == 0) ? HIST - 1 : s - 1;
         end
         horiz_delay[c % DELAY] = hpss_pkg::GUIDE_W'(median_x2(vals));
         window_mag[c % WIN] = mag;
         if (c >= HALF) push_result(c - HALF, c, last);
         if (last) begin
            for (int unsigned b = (c >= HALF) ? c - HALF + 1 : 0; b <= c; b++)
               push_result(b, c, 1'b1);
            slot = (slot + 1) % HIST;
            if (frames < HIST) frames++;
            next_bin = 0;
         end else begin
            next_bin = c + 1;
         end
      endfunction

      function void check(guide_type got);
         guide_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: bin %0d h %0d v %0d last %0d",
                        got.bin, got.horiz, got.vert, got.last);
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected bin %0d h %0d v %0d last %0d, got %0d %0d %0d %0d",
                        want.bin, want.horiz, want.vert, want.last,
                        got.bin, got.horiz, got.vert, got.last);
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [hpss_pkg::MAG_W-1:0]    req_magnitude;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [hpss_pkg::IDX_W-1:0]    rsp_bin_index;
   logic [hpss_pkg::GUIDE_W-1:0]  rsp_horizontal_guide_x2;
   logic [hpss_pkg::GUIDE_W-1:0]  rsp_vertical_guide_x2;
   logic                          rsp_frame_last;
   logic                          csr_we;
   logic [hpss_pkg::CFG_W-1:0]    csr_wdata;

   guide_scoreboard_type sb = new();
   int  cycles;
   bit  hold_request;
   int  burst_left;

   hpss_median_guides_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_magnitude(req_magnitude),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_bin_index(rsp_bin_index),
      .rsp_horizontal_guide_x2(rsp_horizontal_guide_x2),
      .rsp_vertical_guide_x2(rsp_vertical_guide_x2),
      .rsp_frame_last(rsp_frame_last),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side: check every transaction, then pick ready from a randomly redrawn
   // pattern, or hold off for a long stretch on request.
   initial begin : receiver
      int hold_left;
      int pattern;
      guide_type got;
      hold_left = 0;
      pattern = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_bin_index, rsp_horizontal_guide_x2, rsp_vertical_guide_x2,
                    rsp_frame_last};
            sb.check(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 600;
         end
         if (cycles % 64 == 0) pattern = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (pattern)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= (cycles % 3 != 0);
               default: rsp_ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   task automatic send_magnitude(input logic [hpss_pkg::MAG_W-1:0] mag);
      req_valid <= 1'b1;
      req_magnitude <= mag;
      do @(posedge clock); while (!req_ready);
      sb.note_input(mag);
   endtask

   task automatic pause_input(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Sends n magnitudes in bursts of random length, leaning on the extreme values.
   task automatic send_random(input int n, input int max_gap);
      logic [hpss_pkg::MAG_W-1:0] mag;
      for (int i = 0; i < n; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, max_gap));
         end
         burst_left--;
         case ($urandom_range(0, 7))
            0: mag = '0;
            1: mag = '1;
            default: mag = hpss_pkg::MAG_W'($urandom_range(0, 65535));
         endcase
         send_magnitude(mag);
      end
   endtask

   // Waits until every expected transaction has arrived and the block has settled.
   task automatic drain();
      pause_input(1);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_bins(input int unsigned v);
      csr_we <= 1'b1;
      csr_wdata <= v[hpss_pkg::CFG_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_bins(v);
   endtask

   // The frame size only ever shrinks, so no history entry is read before it is written.
   initial begin : stimulus
      logic [hpss_pkg::MAG_W-1:0] corner [12];
      cycles = 0;
      hold_request = 1'b0;
      burst_left = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_magnitude <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out-of-range size acts as the largest frame, so no frame ends here.
      write_bins(4095);
      send_random(100, 4);
      drain();

      // The first transaction lies beyond the new size and ends the open frame.
      write_bins(40);
      send_random(81, 12);
      drain();

      // Directed corners, then shrink the frame below the current bin mid-frame.
      write_bins(20);
      corner = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE,
                 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00};
      foreach (corner[i]) send_magnitude(corner[i]);
      drain();
      write_bins(9);
      send_magnitude(16'h1234);
      drain();

      // Long stall on the result side while items keep coming.
      hold_request = 1'b1;
      send_random(180, 12);
      drain();

      write_bins(8);
      send_random(40, 12);
      drain();

      write_bins(3);
      send_random(30, 12);
      drain();

      write_bins(1);
      send_random(20, 12);
      drain();

      // Zero acts as a frame of one bin.
      write_bins(0);
      send_random(20, 12);
      drain();

      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
